// ===== rtl/core/mclp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared types, codes and constants of the MP4 chapter list parser.
// ----------------------------------------------------------------------------
package mclp_pkg;

  localparam int TitleBytesDefault = 64;

  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_CHAR     = 3'd1;
  localparam logic [2:0] KIND_DONE     = 3'd2;
  localparam logic [2:0] KIND_NOTFOUND = 3'd3;
  localparam logic [2:0] KIND_BAD      = 3'd4;

  localparam logic CFG_FILE_LENGTH   = 1'b0;
  localparam logic CFG_CHAPTER_LIMIT = 1'b1;

  localparam logic [31:0] TYPE_MOOV = 32'h6D6F6F76;
  localparam logic [31:0] TYPE_UDTA = 32'h75647461;
  localparam logic [31:0] TYPE_CHPL = 32'h6368706C;

  // 100 ns ticks per millisecond
  localparam logic [21:0] TICKS_PER_MS = 22'd10000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  num;
    logic [31:0] ms;
    logic [7:0]  ch;
    logic        te;
    logic        tm;
    logic [7:0]  tot;
  } rec_t;

  function automatic rec_t mk_rec(logic [2:0] kind, logic [7:0] num, logic [31:0] ms,
                                  logic [7:0] ch, logic te, logic tm, logic [7:0] tot);
    rec_t r;
    r.kind = kind;
    r.num  = num;
    r.ms   = ms;
    r.ch   = ch;
    r.te   = te;
    r.tm   = tm;
    r.tot  = tot;
    return r;
  endfunction

  function automatic logic [31:0] wanted_type(logic [1:0] lvl);
    logic [31:0] t;
    case (lvl)
      2'd0:    t = TYPE_MOOV;
      2'd1:    t = TYPE_UDTA;
      default: t = TYPE_CHPL;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mp4_chapter_list_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp4_chapter_list_parser_core
// Walks MP4 atoms down moov/udta/chpl one byte per transfer and reports
// chapter start times, title bytes and one outcome record.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data_byte
//  out     | output    | out_valid/out_ready  | record_kind .. chapter_total
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One byte is taken per cycle; the parse step for it completes in the cycle of
// its transfer and writes zero, one or two records into a four-entry output
// queue. The queue sets the rate: in_ready is high while two slots are free.
// The start time is divided by 10000 one quotient byte per start byte, so the
// quotient is complete when the length byte arrives.
// Reset (rst_n low, synchronous) returns to the top-level header at offset 0.
// A stall on out_ready fills the queue and then drops in_ready.
// ----------------------------------------------------------------------------
module mp4_chapter_list_parser_core #(
  parameter int TITLE_BYTES = mclp_pkg::TitleBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_record_kind,
  output logic [7:0]       out_chapter_number,
  output logic [31:0]      out_chapter_ms,
  output logic [7:0]       out_title_char,
  output logic             out_title_end,
  output logic             out_title_missing,
  output logic [7:0]       out_chapter_total,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  // parse phases
  localparam logic [2:0] PH_HDR      = 3'd0;
  localparam logic [2:0] PH_LARGE    = 3'd1;
  localparam logic [2:0] PH_SKIP     = 3'd2;
  localparam logic [2:0] PH_CHPLHEAD = 3'd3;
  localparam logic [2:0] PH_ENTRY    = 3'd4;
  localparam logic [2:0] PH_TITLE    = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  localparam logic [7:0] KEEP_MAX = 8'(TITLE_BYTES - 1);
  localparam int         QDEPTH   = 4;

  // configuration
  logic [31:0] flen_r;
  logic [7:0]  climit_r;

  // parser state
  logic [31:0] pos_r, pos_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [63:0] lrg_r, lrg_nxt;
  logic [31:0] org_r, org_nxt;
  logic [31:0] rend1_r, rend1_nxt;
  logic [31:0] rend2_r, rend2_nxt;
  logic [31:0] rend3_r, rend3_nxt;
  logic [7:0]  decl_r, decl_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  kept_r, kept_nxt;
  logic [1:0]  lvl_r, lvl_nxt;
  logic        first_r, first_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  pkind_r, pkind_nxt;
  logic [7:0]  ptot_r, ptot_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic [13:0] rem_r, rem_nxt;

  // output queue
  mclp_pkg::rec_t q_r [QDEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] qcnt_r;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign in_ready = (qcnt_r <= 3'(QDEPTH - 2));
  assign out_valid = (qcnt_r != 3'd0);

  // step results
  mclp_pkg::rec_t rec_v [2];
  logic [1:0]  nrec;

  // combinational step
  logic [7:0]  b;
  logic [32:0] np;
  logic [31:0] k;
  logic [31:0] lend32;
  logic [32:0] lend;
  logic        fh_go;
  logic [31:0] fh_size, fh_type;
  logic [4:0]  fh_hs;
  logic [32:0] fh_target;
  logic        eh_go;
  logic [32:0] eh_at, eh_end;
  logic        ne_go;
  logic        oc_go;
  logic [2:0]  oc_kind;
  logic [7:0]  oc_tot;
  logic [21:0] dv_val;
  logic [7:0]  dv_q;
  logic [31:0] sz0;

  always_comb begin
    b   = in_data_byte;
    np  = {1'b0, pos_r} + 33'd1;
    k   = pos_r - org_r;
    case (lvl_r)
      2'd0:    lend32 = flen_r;
      2'd1:    lend32 = rend1_r;
      2'd2:    lend32 = rend2_r;
      default: lend32 = rend3_r;
    endcase
    lend = {1'b0, lend32};

    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    lrg_nxt   = lrg_r;
    org_nxt   = org_r;
    rend1_nxt = rend1_r;
    rend2_nxt = rend2_r;
    rend3_nxt = rend3_r;
    decl_nxt  = decl_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    kept_nxt  = kept_r;
    lvl_nxt   = lvl_r;
    first_nxt = first_r;
    pend_nxt  = pend_r;
    pkind_nxt = pkind_r;
    ptot_nxt  = ptot_r;
    ms_nxt    = ms_r;
    rem_nxt   = rem_r;

    rec_v[0] = '0;
    rec_v[1] = '0;
    nrec     = 2'd0;
    fh_go    = 1'b0;
    fh_size  = '0;
    fh_type  = '0;
    fh_hs    = '0;
    fh_target = '0;
    eh_go    = 1'b0;
    eh_at    = '0;
    eh_end   = '0;
    ne_go    = 1'b0;
    oc_go    = 1'b0;
    oc_kind  = mclp_pkg::KIND_DONE;
    oc_tot   = '0;
    sz0      = lend32 - org_r;

    // one quotient byte of the start time per entry byte
    dv_val = {((k == 32'd0) ? 14'd0 : rem_r), b};
    dv_q   = '0;
    for (int i = 7; i >= 0; i--) begin
      if (dv_val >= (mclp_pkg::TICKS_PER_MS << i)) begin
        dv_val  = dv_val - (mclp_pkg::TICKS_PER_MS << i);
        dv_q[i] = 1'b1;
      end
    end

    if (in_xfer) begin
      pos_nxt = np[31:0];
      // a held outcome goes out first
      if (pend_r) begin
        pend_nxt = 1'b0;
        rec_v[0] = mclp_pkg::mk_rec(pkind_r, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0, ptot_r);
        nrec     = 2'd1;
      end
      case (phase_r)
        PH_HDR: begin
          if (k == 32'd0 && ({1'b0, pos_r} + 33'd8) > lend) begin
            oc_go   = 1'b1;
            oc_kind = mclp_pkg::KIND_NOTFOUND;
          end else begin
            hdr_nxt = {hdr_r[55:0], b};
            if (k >= 32'd7) begin
              if (hdr_nxt[63:32] == 32'd1) begin
                if (({1'b0, org_r} + 33'd16) > lend) begin
                  oc_go   = 1'b1;
                  oc_kind = mclp_pkg::KIND_BAD;
                end else begin
                  phase_nxt = PH_LARGE;
                end
              end else begin
                fh_go   = 1'b1;
                fh_size = (hdr_nxt[63:32] == 32'd0) ? sz0 : hdr_nxt[63:32];
                fh_hs   = 5'd8;
                fh_type = hdr_nxt[31:0];
              end
            end
          end
        end
        PH_LARGE: begin
          lrg_nxt = {lrg_r[55:0], b};
          if (k >= 32'd15) begin
            if (lrg_nxt[63:32] != 32'd0) begin
              oc_go   = 1'b1;
              oc_kind = mclp_pkg::KIND_BAD;
            end else begin
              fh_go   = 1'b1;
              fh_size = lrg_nxt[31:0];
              fh_hs   = 5'd16;
              fh_type = hdr_r[31:0];
            end
          end
        end
        PH_SKIP: begin
          if (np == {1'b0, org_r}) begin
            eh_go  = 1'b1;
            eh_at  = np;
            eh_end = lend;
          end
        end
        PH_CHPLHEAD: begin
          if (k >= 32'd8) begin
            decl_nxt = b;
            cnt_nxt  = 8'd0;
            ne_go    = 1'b1;
          end
        end
        PH_ENTRY: begin
          if (k < 32'd8) begin
            ms_nxt  = {ms_r[23:0], dv_q};
            rem_nxt = dv_val[13:0];
          end else if ((np + 33'(b)) > {1'b0, rend3_r}) begin
            oc_go   = 1'b1;
            oc_kind = mclp_pkg::KIND_BAD;
          end else begin
            left_nxt = b;
            kept_nxt = (b < KEEP_MAX) ? b : KEEP_MAX;
            if (b == 8'd0) begin
              rec_v[nrec[0]] = mclp_pkg::mk_rec(mclp_pkg::KIND_START, cnt_r, ms_r,
                                                8'd0, 1'b1, 1'b1, 8'd0);
              nrec    = nrec + 2'd1;
              cnt_nxt = cnt_r + 8'd1;
              ne_go   = 1'b1;
            end else begin
              first_nxt = 1'b1;
              phase_nxt = PH_TITLE;
            end
          end
        end
        PH_TITLE: begin
          if (first_r) begin
            first_nxt = 1'b0;
            if (b == 8'd0) begin
              kept_nxt = 8'd0;
              rec_v[nrec[0]] = mclp_pkg::mk_rec(mclp_pkg::KIND_START, cnt_r, ms_r,
                                                8'd0, 1'b1, 1'b1, 8'd0);
            end else begin
              rec_v[nrec[0]] = mclp_pkg::mk_rec(mclp_pkg::KIND_START, cnt_r, ms_r,
                                                8'd0, 1'b0, 1'b0, 8'd0);
            end
            nrec = nrec + 2'd1;
          end
          if (kept_nxt != 8'd0) begin
            rec_v[nrec[0]] = mclp_pkg::mk_rec(mclp_pkg::KIND_CHAR, cnt_r, 32'd0, b,
                                              kept_nxt == 8'd1, 1'b0, 8'd0);
            nrec     = nrec + 2'd1;
            kept_nxt = kept_nxt - 8'd1;
          end
          if (left_r != 8'd0) begin
            left_nxt = left_r - 8'd1;
          end
          if (left_nxt == 8'd0) begin
            cnt_nxt = cnt_r + 8'd1;
            ne_go   = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // close an atom header
      if (fh_go) begin
        fh_target = {1'b0, org_r} + 33'(fh_size);
        if (fh_size < 32'(fh_hs) || fh_target > lend) begin
          oc_go   = 1'b1;
          oc_kind = mclp_pkg::KIND_BAD;
        end else if (lvl_r != 2'd3 && fh_type == mclp_pkg::wanted_type(lvl_r)) begin
          lvl_nxt = lvl_r + 2'd1;
          case (lvl_r)
            2'd0:    rend1_nxt = fh_target[31:0];
            2'd1:    rend2_nxt = fh_target[31:0];
            default: rend3_nxt = fh_target[31:0];
          endcase
          if (lvl_r == 2'd2) begin
            if ((fh_size - 32'(fh_hs)) < 32'd9) begin
              oc_go   = 1'b1;
              oc_kind = mclp_pkg::KIND_BAD;
            end else begin
              phase_nxt = PH_CHPLHEAD;
              org_nxt   = np[31:0];
            end
          end else begin
            eh_go  = 1'b1;
            eh_at  = np;
            eh_end = {1'b0, fh_target[31:0]};
          end
        end else if (fh_target == np) begin
          eh_go  = 1'b1;
          eh_at  = np;
          eh_end = lend;
        end else begin
          phase_nxt = PH_SKIP;
          org_nxt   = fh_target[31:0];
        end
      end

      // open the next header
      if (eh_go) begin
        org_nxt   = eh_at[31:0];
        phase_nxt = PH_HDR;
        if ((eh_at + 33'd8) > eh_end) begin
          oc_go   = 1'b1;
          oc_kind = mclp_pkg::KIND_NOTFOUND;
        end
      end

      // advance to the next chapter entry
      if (ne_go) begin
        if (cnt_nxt >= decl_nxt || cnt_nxt >= climit_r) begin
          oc_go   = 1'b1;
          oc_kind = mclp_pkg::KIND_DONE;
          oc_tot  = cnt_nxt;
        end else if ((np + 33'd9) > {1'b0, rend3_r}) begin
          oc_go   = 1'b1;
          oc_kind = mclp_pkg::KIND_BAD;
        end else begin
          phase_nxt = PH_ENTRY;
          org_nxt   = np[31:0];
        end
      end

      // outcome is always the last record of a step; hold it if two are out
      if (oc_go) begin
        phase_nxt = PH_DONE;
        if (nrec == 2'd2) begin
          pend_nxt  = 1'b1;
          pkind_nxt = oc_kind;
          ptot_nxt  = oc_tot;
        end else begin
          rec_v[nrec[0]] = mclp_pkg::mk_rec(oc_kind, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0,
                                            oc_tot);
          nrec = nrec + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r   <= '0;
      climit_r <= 8'd255;
      pos_r    <= '0;
      phase_r  <= PH_HDR;
      hdr_r    <= '0;
      lrg_r    <= '0;
      org_r    <= '0;
      rend1_r  <= '0;
      rend2_r  <= '0;
      rend3_r  <= '0;
      decl_r   <= '0;
      cnt_r    <= '0;
      left_r   <= '0;
      kept_r   <= '0;
      lvl_r    <= '0;
      first_r  <= 1'b0;
      pend_r   <= 1'b0;
      pkind_r  <= '0;
      ptot_r   <= '0;
      ms_r     <= '0;
      rem_r    <= '0;
      wp_r     <= '0;
      rp_r     <= '0;
      qcnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == mclp_pkg::CFG_FILE_LENGTH) begin
          flen_r <= cfg_wdata;
        end else begin
          climit_r <= cfg_wdata[7:0];
        end
      end
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      lrg_r   <= lrg_nxt;
      org_r   <= org_nxt;
      rend1_r <= rend1_nxt;
      rend2_r <= rend2_nxt;
      rend3_r <= rend3_nxt;
      decl_r  <= decl_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      kept_r  <= kept_nxt;
      lvl_r   <= lvl_nxt;
      first_r <= first_nxt;
      pend_r  <= pend_nxt;
      pkind_r <= pkind_nxt;
      ptot_r  <= ptot_nxt;
      ms_r    <= ms_nxt;
      rem_r   <= rem_nxt;
      wp_r    <= wp_r + nrec;
      if (out_xfer) begin
        rp_r <= rp_r + 2'd1;
      end
      qcnt_r <= qcnt_r + {1'b0, nrec} - {2'b00, out_xfer};
    end
  end

  // queue payload: no reset
  always_ff @(posedge clk) begin
    if (nrec != 2'd0) begin
      q_r[wp_r] <= rec_v[0];
    end
    if (nrec == 2'd2) begin
      q_r[wp_r + 2'd1] <= rec_v[1];
    end
  end

  assign out_record_kind    = q_r[rp_r].kind;
  assign out_chapter_number = q_r[rp_r].num;
  assign out_chapter_ms     = q_r[rp_r].ms;
  assign out_title_char     = q_r[rp_r].ch;
  assign out_title_end      = q_r[rp_r].te;
  assign out_title_missing  = q_r[rp_r].tm;
  assign out_chapter_total  = q_r[rp_r].tot;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 3'(QDEPTH))
    else $error("output queue overfilled");

  a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> phase_r == PH_DONE)
    else $error("held outcome outside done phase");

  a_entry_level: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENTRY || phase_r == PH_TITLE || phase_r == PH_CHPLHEAD)
      |-> lvl_r == 2'd3)
    else $error("chapter entries parsed above chpl level");

  a_total_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind != mclp_pkg::KIND_DONE) |-> out_chapter_total == 8'd0)
    else $error("chapter total on a non-finished record");
`endif

endmodule
`default_nettype wire

// ===== tb/mclp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclp_checker
// Watches the byte, record and register ports of the chapter list parser,
// predicts the records of every accepted byte and compares each accepted
// record with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mclp_checker #(
  parameter int TITLE_BYTES = mclp_pkg::TitleBytesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_record_kind,
  input  logic [7:0]  out_chapter_number,
  input  logic [31:0] out_chapter_ms,
  input  logic [7:0]  out_title_char,
  input  logic        out_title_end,
  input  logic        out_title_missing,
  input  logic [7:0]  out_chapter_total,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          waiting
);

  typedef enum logic [2:0] {
    SCAN_HDR, SCAN_LARGE, SKIP_ATOM, CHPL_HEAD, ENTRY_HEAD, TITLE_BODY, PARSE_DONE
  } walk_t;

  mclp_pkg::rec_t expected_recs[$];
  logic [31:0] flen;
  logic [7:0]  climit;
  logic [31:0] pos;
  walk_t       phase;
  logic [63:0] hdr_word;
  logic [63:0] large_word;
  logic [31:0] origin;
  logic [31:0] rend[4];
  logic [7:0]  declared;
  logic [7:0]  counter;
  logic [7:0]  tleft;
  logic [7:0]  tkept;
  logic [1:0]  lvl;
  logic        first_t;
  logic        held;
  logic [2:0]  held_kind;
  logic [7:0]  held_tot;
  int          made;
  int          fail_count = 0;

  assign waiting    = expected_recs.size();
  assign mismatches = fail_count;

  function automatic logic [63:0] range_limit();
    return (lvl == 2'd0) ? {32'd0, flen} : {32'd0, rend[lvl]};
  endfunction

  function automatic logic [31:0] path_type(logic [1:0] l);
    case (l)
      2'd0:    return mclp_pkg::TYPE_MOOV;
      2'd1:    return mclp_pkg::TYPE_UDTA;
      default: return mclp_pkg::TYPE_CHPL;
    endcase
  endfunction

  function automatic void add_rec(logic [2:0] kind, logic [7:0] num, logic [31:0] ms,
                                  logic [7:0] ch, logic te, logic tm, logic [7:0] tot);
    mclp_pkg::rec_t r;
    r.kind = kind;
    r.num  = num;
    r.ms   = ms;
    r.ch   = ch;
    r.te   = te;
    r.tm   = tm;
    r.tot  = tot;
    expected_recs.push_back(r);
    made++;
  endfunction

  // At most two records per byte; a third one waits for the next byte.
  function automatic void conclude(logic [2:0] kind, logic [7:0] tot);
    phase = PARSE_DONE;
    if (made >= 2) begin
      held      = 1'b1;
      held_kind = kind;
      held_tot  = tot;
    end else begin
      add_rec(kind, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0, tot);
    end
  endfunction

  function automatic void open_header(logic [63:0] at);
    origin = at[31:0];
    phase  = SCAN_HDR;
    if (at + 64'd8 > range_limit()) conclude(mclp_pkg::KIND_NOTFOUND, 8'd0);
  endfunction

  function automatic void open_entry(logic [63:0] at);
    if (counter >= declared || counter >= climit) begin
      conclude(mclp_pkg::KIND_DONE, counter);
    end else if (at + 64'd9 > {32'd0, rend[3]}) begin
      conclude(mclp_pkg::KIND_BAD, 8'd0);
    end else begin
      phase  = ENTRY_HEAD;
      origin = at[31:0];
    end
  endfunction

  function automatic void close_header(logic [31:0] size, logic [31:0] hs,
                                       logic [31:0] atype, logic [63:0] np);
    logic [63:0] target;
    target = {32'd0, origin} + {32'd0, size};
    if (size < hs || target > range_limit()) begin
      conclude(mclp_pkg::KIND_BAD, 8'd0);
    end else if (lvl != 2'd3 && atype == path_type(lvl)) begin
      lvl++;
      rend[lvl] = target[31:0];
      if (lvl == 2'd3) begin
        if (size - hs < 32'd9) begin
          conclude(mclp_pkg::KIND_BAD, 8'd0);
        end else begin
          phase  = CHPL_HEAD;
          origin = np[31:0];
        end
      end else begin
        open_header(np);
      end
    end else if (target == np) begin
      open_header(np);
    end else begin
      phase  = SKIP_ATOM;
      origin = target[31:0];
    end
  endfunction

  function automatic void clear_parse();
    expected_recs.delete();
    flen       = '0;
    climit     = 8'd255;
    pos        = '0;
    phase      = SCAN_HDR;
    hdr_word   = '0;
    large_word = '0;
    origin     = '0;
    foreach (rend[i]) rend[i] = '0;
    declared   = '0;
    counter    = '0;
    tleft      = '0;
    tkept      = '0;
    lvl        = '0;
    first_t    = 1'b0;
    held       = 1'b0;
    held_kind  = '0;
    held_tot   = '0;
  endfunction

  // Predict the records of one file byte.
  function automatic void parse_byte(logic [7:0] b);
    logic [63:0] np;
    logic [31:0] k;
    logic [31:0] size;
    logic [31:0] ms;
    np   = {32'd0, pos} + 64'd1;
    k    = pos - origin;
    made = 0;
    ms   = '0;
    if (held) begin
      held = 1'b0;
      add_rec(held_kind, 8'd0, 32'd0, 8'd0, 1'b0, 1'b0, held_tot);
    end
    case (phase)
      SCAN_HDR: begin
        if (k == 0 && {32'd0, pos} + 64'd8 > range_limit()) begin
          conclude(mclp_pkg::KIND_NOTFOUND, 8'd0);
        end else begin
          hdr_word = {hdr_word[55:0], b};
          if (k >= 7) begin
            size = hdr_word[63:32];
            if (size == 32'd1) begin
              if ({32'd0, origin} + 64'd16 > range_limit()) begin
                conclude(mclp_pkg::KIND_BAD, 8'd0);
              end else begin
                phase = SCAN_LARGE;
              end
            end else begin
              if (size == 32'd0) size = 32'(range_limit() - {32'd0, origin});
              close_header(size, 32'd8, hdr_word[31:0], np);
            end
          end
        end
      end
      SCAN_LARGE: begin
        large_word = {large_word[55:0], b};
        if (k >= 15) begin
          if (large_word[63:32] != 32'd0) conclude(mclp_pkg::KIND_BAD, 8'd0);
          else close_header(large_word[31:0], 32'd16, hdr_word[31:0], np);
        end
      end
      SKIP_ATOM: begin
        if (np == {32'd0, origin}) open_header(np);
      end
      CHPL_HEAD: begin
        if (k >= 8) begin
          declared = b;
          counter  = '0;
          open_entry(np);
        end
      end
      ENTRY_HEAD: begin
        if (k < 8) begin
          hdr_word = {hdr_word[55:0], b};
        end else if (np + {56'd0, b} > {32'd0, rend[3]}) begin
          conclude(mclp_pkg::KIND_BAD, 8'd0);
        end else begin
          tleft = b;
          tkept = (b < 8'(TITLE_BYTES - 1)) ? b : 8'(TITLE_BYTES - 1);
          if (b == 8'd0) begin
            add_rec(mclp_pkg::KIND_START, counter, 32'(hdr_word / 64'd10000), 8'd0,
                    1'b1, 1'b1, 8'd0);
            counter++;
            open_entry(np);
          end else begin
            first_t = 1'b1;
            phase   = TITLE_BODY;
          end
        end
      end
      TITLE_BODY: begin
        if (first_t) begin
          ms      = 32'(hdr_word / 64'd10000);
          first_t = 1'b0;
          if (b == 8'd0) begin
            tkept = '0;
            add_rec(mclp_pkg::KIND_START, counter, ms, 8'd0, 1'b1, 1'b1, 8'd0);
          end else begin
            add_rec(mclp_pkg::KIND_START, counter, ms, 8'd0, 1'b0, 1'b0, 8'd0);
          end
        end
        if (tkept > 0) begin
          add_rec(mclp_pkg::KIND_CHAR, counter, 32'd0, b, tkept == 8'd1, 1'b0, 8'd0);
          tkept--;
        end
        if (tleft > 0) tleft--;
        if (tleft == 0) begin
          counter++;
          open_entry(np);
        end
      end
      default: ;
    endcase
    pos = np[31:0];
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    mclp_pkg::rec_t r;
    if (!rst_n) begin
      clear_parse();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mclp_pkg::CFG_FILE_LENGTH) flen = cfg_wdata;
        else climit = cfg_wdata[7:0];
      end
      if (in_valid && in_ready) parse_byte(in_data_byte);
      if (out_valid && out_ready) begin
        if (expected_recs.size() == 0) begin
          $error("record kind %0d with nothing expected", out_record_kind);
          fail_count++;
        end else begin
          r = expected_recs.pop_front();
          check_field("record_kind", r.kind, out_record_kind);
          check_field("chapter_number", r.num, out_chapter_number);
          check_field("chapter_ms", r.ms, out_chapter_ms);
          check_field("title_char", r.ch, out_title_char);
          check_field("title_end", r.te, out_title_end);
          check_field("title_missing", r.tm, out_title_missing);
          check_field("chapter_total", r.tot, out_chapter_total);
        end
      end
    end
  end

endmodule

// ===== tb/tb_mp4_chapter_list_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mp4_chapter_list_parser_core
// Streams one synthetic MP4 file (junk atoms, a largesize atom, moov/udta/chpl
// with random chapters) through the parser under random idling on both sides,
// retunes the registers between phases and lets the checker judge the records.
// ----------------------------------------------------------------------------
module tb_mp4_chapter_list_parser_core;

  localparam int TB_TITLE     = mclp_pkg::TitleBytesDefault;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  // Types of the atoms the parser must skip
  localparam logic [31:0] TYPE_FREE = 32'h66726565;
  localparam logic [31:0] TYPE_SKIP = 32'h736B6970;
  localparam logic [31:0] TYPE_MVHD = 32'h6D766864;
  localparam logic [31:0] TYPE_META = 32'h6D657461;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_record_kind;
  logic [7:0]  out_chapter_number;
  logic [31:0] out_chapter_ms;
  logic [7:0]  out_title_char;
  logic        out_title_end;
  logic        out_title_missing;
  logic [7:0]  out_chapter_total;
  logic        cfg_we = 1'b0;
  logic        cfg_index = mclp_pkg::CFG_FILE_LENGTH;
  logic [31:0] cfg_wdata = '0;
  int          mismatches;
  int          waiting;

  logic [7:0]  file_bytes[$];
  logic [7:0]  entry_bytes[$];
  int          sent_count = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  mp4_chapter_list_parser_core #(.TITLE_BYTES(TB_TITLE)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte,
    .out_valid, .out_ready, .out_record_kind, .out_chapter_number, .out_chapter_ms,
    .out_title_char, .out_title_end, .out_title_missing, .out_chapter_total,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  mclp_checker #(.TITLE_BYTES(TB_TITLE)) u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte,
    .out_valid, .out_ready, .out_record_kind, .out_chapter_number, .out_chapter_ms,
    .out_title_char, .out_title_end, .out_title_missing, .out_chapter_total,
    .cfg_we, .cfg_index, .cfg_wdata, .mismatches, .waiting
  );

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic put_junk(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endtask

  // Append one chapter entry: 64-bit start in 100 ns ticks, length, title.
  task automatic add_chapter(input logic [63:0] ticks);
    int pick;
    int len;
    pick = $urandom_range(0, 15);
    if (pick == 0) len = 0;
    else if (pick == 1) len = $urandom_range(64, 90);
    else if (pick == 2) len = TB_TITLE - 1;
    else len = $urandom_range(1, 20);
    for (int i = 7; i >= 0; i--) entry_bytes.push_back(ticks[8*i +: 8]);
    entry_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++) begin
      // sometimes open the title with a zero byte
      if (i == 0 && $urandom_range(0, 9) == 0) entry_bytes.push_back(8'd0);
      else entry_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted record is out, then let the pipe settle.
  task automatic drain();
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Receiver: random ready bursts, one long hold-off to back up the input,
  // and steady ready in the last part.
  initial begin
    bit held_off;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (!held_off && sent_count >= 150) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7);
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_mp4_chapter_list_parser_core: FAIL");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    int          junk_top;
    int          junk_wide;
    int          junk_mvhd;
    int          junk_meta;
    int          chpl_size;
    int          udta_size;
    int          payload_at;
    int          cut_a;
    int          cut_b;
    logic [63:0] ticks;

    // Build the file: first the chapter entries, then the atoms around them.
    add_chapter(64'd0);
    add_chapter(64'hFFFF_FFFF_FFFF_FFFF);
    add_chapter(64'd10000 * 64'hFFFF_FFFF + 64'd9999);
    while (entry_bytes.size() < 950) begin
      if ($urandom_range(0, 1)) ticks = {$urandom, $urandom};
      else ticks = 64'($urandom_range(0, 100000000));
      add_chapter(ticks);
    end
    junk_top  = $urandom_range(0, 12);
    junk_wide = $urandom_range(0, 12);
    junk_mvhd = $urandom_range(0, 12);
    junk_meta = $urandom_range(0, 12);
    chpl_size = 8 + 9 + entry_bytes.size();
    udta_size = 16 + 8 + junk_meta + chpl_size;

    put_word(32'(8 + junk_top));           // plain atom to skip
    put_word(TYPE_FREE);
    put_junk(junk_top);
    put_word(32'd1);                       // largesize atom to skip
    put_word(TYPE_SKIP);
    put_word(32'd0);
    put_word(32'(16 + junk_wide));
    put_junk(junk_wide);
    put_word(32'd0);                       // moov runs to the end of the file
    put_word(mclp_pkg::TYPE_MOOV);
    put_word(32'(8 + junk_mvhd));
    put_word(TYPE_MVHD);
    put_junk(junk_mvhd);
    put_word(32'd1);                       // udta in largesize form
    put_word(mclp_pkg::TYPE_UDTA);
    put_word(32'd0);
    put_word(32'(udta_size));
    put_word(32'(8 + junk_meta));
    put_word(TYPE_META);
    put_junk(junk_meta);
    put_word(32'(chpl_size));
    put_word(mclp_pkg::TYPE_CHPL);
    payload_at = file_bytes.size();
    put_word(32'h0100_0000);               // version, flags
    put_word(32'd0);                       // reserved
    file_bytes.push_back(8'd255);          // chapters declared
    foreach (entry_bytes[i]) file_bytes.push_back(entry_bytes[i]);
    put_junk(40);                          // trailing bytes, ignored after the outcome

    cut_a = payload_at + 9 + entry_bytes.size() / 3;
    cut_b = payload_at + 9 + (entry_bytes.size() * 4) / 5;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(mclp_pkg::CFG_FILE_LENGTH, 32'hFFFF_FFFF);
    write_reg(mclp_pkg::CFG_CHAPTER_LIMIT, 32'd255);

    foreach (file_bytes[i]) begin
      if (i == cut_a || i == cut_b) begin
        in_valid <= 1'b0;
        @(posedge clk);
        drain();
        if (i == cut_a) begin
          // moov's end is already fixed, so the top-level length no longer matters
          write_reg(mclp_pkg::CFG_FILE_LENGTH, $urandom);
          write_reg(mclp_pkg::CFG_CHAPTER_LIMIT, 32'($urandom_range(100, 255)));
        end else begin
          // stop at the next entry boundary with a finished record
          calm = 1'b1;
          write_reg(mclp_pkg::CFG_CHAPTER_LIMIT, 32'd0);
        end
      end
      send_byte(file_bytes[i]);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    drain();
    write_reg(mclp_pkg::CFG_FILE_LENGTH, 32'd0);
    write_reg(mclp_pkg::CFG_CHAPTER_LIMIT, 32'd255);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && waiting == 0) begin
      $display("tb_mp4_chapter_list_parser_core: PASS");
    end else begin
      $display("tb_mp4_chapter_list_parser_core: FAIL");
    end
    $finish;
  end

endmodule
